>>> rtl/core/bap_pkg.sv
// Shared types and constants of the 2x2 box-average mosaic block.
package bap_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 9;
  localparam int CFG_W   = 10;
  localparam int SUM_W   = PIX_W + 1;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // Register indexes on the configuration port.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Beat of a four-result burst that carries the last flag.
  localparam logic [1:0] LAST_BEAT = 2'd3;

  // One finished block: its average and the coordinates of its lower-right pixel.
  typedef struct packed {
    logic [PIX_W-1:0]   avg;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } blk_job_t;

endpackage

>>> rtl/core/bap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bap_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bap_front.sv
// Front end: raster counters, pair sums, line store and block-sum stage.
module bap_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [bap_pkg::PIX_W-1:0]  in_pixel,
  output logic                       in_stall,
  input  logic [bap_pkg::CFG_W-1:0]  cfg_width,
  input  logic [bap_pkg::CFG_W-1:0]  cfg_height,
  output logic                       push,
  output bap_pkg::blk_job_t          job,
  input  logic                       full
);

  localparam int CW    = $clog2(MAX_WIDTH) + 1;
  localparam int RW    = $clog2(MAX_HEIGHT) + 1;
  localparam int WW    = (CW > bap_pkg::CFG_W) ? CW : bap_pkg::CFG_W;
  localparam int HW    = (RW > bap_pkg::CFG_W) ? RW : bap_pkg::CFG_W;
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [bap_pkg::PIX_W-1:0]    left_r, left_nxt;
  logic                         s_valid_r, s_valid_nxt;
  logic [bap_pkg::SUM_W-1:0]    s_sum_r, s_sum_nxt;
  logic [bap_pkg::COORD_W-1:0]  s_row_r, s_row_nxt;
  logic [bap_pkg::COORD_W-1:0]  s_col_r, s_col_nxt;

  logic [WW-1:0]               w_eff, wcut;
  logic [HW-1:0]               h_eff, hcut;
  logic                        accept, in_range, pair_end, is_blk;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_addr;
  logic [bap_pkg::SUM_W-1:0]   pair_sum, line_sum;
  logic [bap_pkg::SUM_W:0]     blk_sum;
  logic [CW-1:0]               col_inc;
  logic [RW-1:0]               row_inc;

  // Out-of-range sizes clamp to 2..MAX.
  always_comb begin
    if (WW'(cfg_width) < WW'(2)) begin
      w_eff = WW'(2);
    end else if (WW'(cfg_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (HW'(cfg_height) < HW'(2)) begin
      h_eff = HW'(2);
    end else if (HW'(cfg_height) > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height);
    end
  end

  assign wcut = {w_eff[WW-1:1], 1'b0};
  assign hcut = {h_eff[HW-1:1], 1'b0};

  // A stuck block-sum stage holds the line store read data, so no new word enters.
  assign in_stall = s_valid_r && full;
  assign accept   = in_valid && !in_stall;
  assign push     = s_valid_r && !full;

  assign in_range = (WW'(col_r) < wcut) && (HW'(row_r) < hcut);
  assign pair_end = in_range && col_r[0];
  assign is_blk   = pair_end && row_r[0];
  assign pair_sum = {1'b0, left_r} + {1'b0, in_pixel};
  assign ram_addr = AW'(col_r >> 1);
  assign ram_we   = accept && pair_end && !row_r[0];
  assign ram_re   = accept && is_blk;
  assign col_inc  = col_r + 1'b1;
  assign row_inc  = row_r + 1'b1;

  bap_ram #(
    .WIDTH (bap_pkg::SUM_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (pair_sum),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (line_sum)
  );

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    left_nxt    = left_r;
    s_valid_nxt = s_valid_r && full;
    s_sum_nxt   = s_sum_r;
    s_row_nxt   = s_row_r;
    s_col_nxt   = s_col_r;
    if (accept) begin
      if (in_range && !col_r[0]) begin
        left_nxt = in_pixel;
      end
      if (is_blk) begin
        s_valid_nxt = 1'b1;
        s_sum_nxt   = pair_sum;
        s_row_nxt   = bap_pkg::COORD_W'(row_r);
        s_col_nxt   = bap_pkg::COORD_W'(col_r);
      end
      if (WW'(col_inc) >= w_eff) begin
        col_nxt = '0;
        row_nxt = (HW'(row_inc) >= h_eff) ? '0 : row_inc;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      left_r    <= '0;
      s_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      left_r    <= left_nxt;
      s_valid_r <= s_valid_nxt;
    end
    s_sum_r <= s_sum_nxt;
    s_row_r <= s_row_nxt;
    s_col_r <= s_col_nxt;
  end

  assign blk_sum = {1'b0, line_sum} + {1'b0, s_sum_r};
  assign job.avg = blk_sum[bap_pkg::SUM_W:2];
  assign job.row = s_row_r;
  assign job.col = s_col_r;

endmodule

>>> rtl/core/bap_fifo.sv
// Short queue of finished blocks between the front end and the output sequencer.
module bap_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bap_pkg::blk_job_t push_job,
  output logic              full,
  input  logic              pop,
  output bap_pkg::blk_job_t head_job,
  output logic              empty
);

  bap_pkg::blk_job_t           slot_r [bap_pkg::QDEPTH];
  logic [bap_pkg::QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [bap_pkg::QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [bap_pkg::QPTR_W:0]    count_r, count_nxt;

  assign full     = (count_r == (bap_pkg::QPTR_W + 1)'(bap_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_job = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/core/bap_back.sv
// Back end: expands each block into four output words through an output register.
module bap_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         empty,
  input  bap_pkg::blk_job_t            head_job,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bap_pkg::PIX_W-1:0]    out_pixel_out,
  output logic [bap_pkg::COORD_W-1:0]  out_row,
  output logic [bap_pkg::COORD_W-1:0]  out_col,
  output logic                         out_block_last
);

  logic                         valid_r, valid_nxt;
  logic [1:0]                   beat_r, beat_nxt;
  logic [bap_pkg::PIX_W-1:0]    pix_r, pix_nxt;
  logic [bap_pkg::COORD_W-1:0]  row_r, row_nxt;
  logic [bap_pkg::COORD_W-1:0]  col_r, col_nxt;
  logic                         last_r, last_nxt;
  logic                         adv, load;

  assign adv  = !valid_r || !out_stall;
  assign load = adv && !empty;
  assign pop  = load && (beat_r == bap_pkg::LAST_BEAT);

  // Beats run upper-left, upper-right, lower-left, lower-right.
  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    pix_nxt   = pix_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    last_nxt  = last_r;
    if (adv) begin
      valid_nxt = load;
    end
    if (load) begin
      beat_nxt = beat_r + 1'b1;
      pix_nxt  = head_job.avg;
      row_nxt  = beat_r[1] ? head_job.row : head_job.row - 1'b1;
      col_nxt  = beat_r[0] ? head_job.col : head_job.col - 1'b1;
      last_nxt = (beat_r == bap_pkg::LAST_BEAT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
    pix_r  <= pix_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_pixel_out  = pix_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_block_last = last_r;

endmodule

>>> rtl/core/block_average_pixelate_2x2.sv
// Top level of the 2x2 box-average mosaic block.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   in       | in_valid / in_stall    | in_pixel_in
//   out      | out_valid / out_stall  | out_pixel_out, out_row, out_col, out_block_last
//   cfg      | APB psel/penable/write | image_width at 0x0, image_height at 0x4
//
// One pixel word can be taken every cycle while in_stall is low; each block on an
// odd row yields four output words at one per cycle while out_stall is low. The
// block sum leaves the line store in the cycle after the pixel, then waits in a
// four-entry queue. Reset clears counters, queue and output register; the line
// store is not cleared. in_stall rises only when the queue is full.
module block_average_pixelate_2x2 #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [bap_pkg::PIX_W-1:0]    in_pixel_in,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bap_pkg::PIX_W-1:0]    out_pixel_out,
  output logic [bap_pkg::COORD_W-1:0]  out_row,
  output logic [bap_pkg::COORD_W-1:0]  out_col,
  output logic                         out_block_last,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [2:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  logic [bap_pkg::CFG_W-1:0] width_r, width_nxt;
  logic [bap_pkg::CFG_W-1:0] height_r, height_nxt;
  logic                      cfg_wr;
  logic                      push, full, pop, empty;
  bap_pkg::blk_job_t         push_job, head_job;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        bap_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_pwdata[bap_pkg::CFG_W-1:0];
        bap_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_pwdata[bap_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      bap_pkg::REG_IMAGE_WIDTH:  cfg_prdata = 32'(width_r);
      bap_pkg::REG_IMAGE_HEIGHT: cfg_prdata = 32'(height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bap_pkg::CFG_W'(512);
      height_r <= bap_pkg::CFG_W'(512);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  bap_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_pixel   (in_pixel_in),
    .in_stall   (in_stall),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .push       (push),
    .job        (push_job),
    .full       (full)
  );

  bap_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  bap_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_block_last (out_block_last)
  );

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the 2x2 box-average mosaic block.
module tb_top;
  import bap_pkg::*;

  localparam int MAX_SIDE    = 512;
  localparam int LINE_SLOTS  = MAX_SIDE / 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 240;
  localparam int PRIMED_COLS = 32;
  localparam int TALL_ROWS = 32;
  localparam int SETTLE_CYCLES = 10;
  localparam int SHOWN_ERRORS = 10;
  localparam int SIDE_IN  = 0;
  localparam int SIDE_OUT = 1;

  typedef struct {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } mosaic_px_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic [PIX_W-1:0]    in_pixel_in = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PIX_W-1:0]    out_pixel_out;
  logic [COORD_W-1:0]  out_row;
  logic [COORD_W-1:0]  out_col;
  logic                out_block_last;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // Shadow of the block: registers, line store of pair sums and raster position.
  logic [CFG_W-1:0]    width_reg = CFG_W'(MAX_SIDE);
  logic [CFG_W-1:0]    height_reg = CFG_W'(MAX_SIDE);
  logic [SUM_W-1:0]    pair_sums [LINE_SLOTS];
  logic [PIX_W-1:0]    left_px = '0;
  int                  col_at = 0;
  int                  row_at = 0;

  mosaic_px_t          expected_px [$];
  int                  error_count = 0;
  int                  random_sent = 0;
  int                  cycle_count = 0;
  bit                  no_idle [2] = '{1'b0, 1'b0};

  block_average_pixelate_2x2 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_pixel_in    (in_pixel_in),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_block_last (out_block_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  // Each side now and then switches into a run with no waits at all.
  function automatic int draw_pause(int side);
    if ($urandom_range(0, 39) == 0) no_idle[side] = !no_idle[side];
    return no_idle[side] ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int clamp_side(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic void push_block_px(logic [PIX_W-1:0] avg, int r, int c, logic last);
    mosaic_px_t e;
    e.pix  = avg;
    e.row  = COORD_W'(r);
    e.col  = COORD_W'(c);
    e.last = last;
    expected_px.push_back(e);
  endfunction

  // Advances the shadow by one pixel and queues the four words of a finished block.
  function automatic void mosaic_predict(logic [PIX_W-1:0] pix);
    int w, h, slot, total;
    logic [SUM_W-1:0] pair;
    logic [PIX_W-1:0] avg;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    if (col_at < (w & ~1) && row_at < (h & ~1)) begin
      if (col_at % 2 == 0) begin
        left_px = pix;
      end else begin
        pair = SUM_W'(left_px) + SUM_W'(pix);
        slot = col_at / 2;
        if (row_at % 2 == 0) begin
          pair_sums[slot] = pair;
        end else begin
          total = int'(pair_sums[slot]) + int'(pair);
          avg = PIX_W'(total >> 2);
          push_block_px(avg, row_at - 1, col_at - 1, 1'b0);
          push_block_px(avg, row_at - 1, col_at, 1'b0);
          push_block_px(avg, row_at, col_at - 1, 1'b0);
          push_block_px(avg, row_at, col_at, 1'b1);
        end
      end
    end
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) row_at = 0;
    end
  endfunction

  function automatic void note_error();
    error_count++;
  endfunction

  // Result side: random stalls, and every accepted word is checked in order.
  initial begin
    int hold;
    mosaic_px_t e;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          note_error();
          if (error_count <= SHOWN_ERRORS)
            $display("unexpected word: pixel %0d row %0d col %0d last %0b",
                     out_pixel_out, out_row, out_col, out_block_last);
        end else begin
          e = expected_px.pop_front();
          if (out_pixel_out !== e.pix || out_row !== e.row || out_col !== e.col ||
              out_block_last !== e.last) begin
            note_error();
            if (error_count <= SHOWN_ERRORS)
              $display("mismatch: expected %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
                       e.pix, e.row, e.col, e.last,
                       out_pixel_out, out_row, out_col, out_block_last);
          end
        end
        hold = draw_pause(SIDE_OUT);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sends one pixel word; valid stays high into the next word when no wait is drawn.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = draw_pause(SIDE_IN);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    mosaic_predict(pix);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_px.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [CFG_W-1:0] value);
    logic [31:0] word;
    word = $urandom;
    word[CFG_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_idx == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic reg_idx, input logic [CFG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {reg_idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(value)) begin
      note_error();
      if (error_count <= SHOWN_ERRORS)
        $display("register %0d: expected %0d, got %0d", reg_idx, value, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Fills out the current frame so the next pixel lands at row 0, column 0.
  task automatic align_frame();
    while (col_at != 0 || row_at != 0) send_pixel(rand_pixel());
  endtask

  // Registers read back the reset size; the start of row zero then writes the
  // line store entries that every later, narrower frame reads.
  task automatic test_reset_defaults();
    cfg_check(REG_IMAGE_WIDTH, CFG_W'(MAX_SIDE));
    cfg_check(REG_IMAGE_HEIGHT, CFG_W'(MAX_SIDE));
    repeat (PRIMED_COLS) send_pixel(rand_pixel());
    wait_idle();
  endtask

  task automatic test_directed_blocks();
    logic [PIX_W-1:0] extremes [8];
    logic [PIX_W-1:0] odd_frame [9];
    logic [PIX_W-1:0] tiny [4];
    extremes  = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd1, 8'd2};
    odd_frame = '{8'd10, 8'd20, 8'd200, 8'd30, 8'd41, 8'd77, 8'd255, 8'd0, 8'd99};
    tiny      = '{8'd128, 8'd127, 8'd64, 8'd63};
    // Four by two: an all-white block and a block that truncates to zero.
    cfg_write(REG_IMAGE_WIDTH, 10'd4);
    cfg_write(REG_IMAGE_HEIGHT, 10'd2);
    align_frame();
    foreach (extremes[i]) send_pixel(extremes[i]);
    wait_idle();
    // Three by three: the trailing column and row give no output.
    cfg_write(REG_IMAGE_WIDTH, 10'd3);
    cfg_write(REG_IMAGE_HEIGHT, 10'd3);
    foreach (odd_frame[i]) send_pixel(odd_frame[i]);
    wait_idle();
    // Sizes below the minimum act as two by two.
    cfg_write(REG_IMAGE_WIDTH, 10'd0);
    cfg_write(REG_IMAGE_HEIGHT, 10'd1);
    foreach (tiny[i]) send_pixel(tiny[i]);
    wait_idle();
  endtask

  // Narrowest frame at full height: one block for every two rows.
  task automatic test_tall_frame();
    cfg_write(REG_IMAGE_WIDTH, 10'd2);
    cfg_write(REG_IMAGE_HEIGHT, CFG_W'(MAX_SIDE));
    repeat (2 * TALL_ROWS) send_pixel(rand_pixel());
    wait_idle();
  endtask

  function automatic logic [CFG_W-1:0] pick_side();
    case ($urandom_range(0, 19))
      0: return CFG_W'($urandom_range(0, 1));
      1: return CFG_W'($urandom_range(MAX_SIDE + 1, 1023));
      2: return CFG_W'(MAX_SIDE);
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  // Widths stay within the columns whose line store entries are already written.
  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 19))
      0: return CFG_W'($urandom_range(0, 1));
      1: return CFG_W'($urandom_range(13, PRIMED_COLS));
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  // Bursts of pixels with size changes in between, usually in mid frame.
  task automatic test_random_traffic();
    int n;
    int pick;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 2);
      if (pick != 1) cfg_write(REG_IMAGE_WIDTH, pick_width());
      if (pick != 0) cfg_write(REG_IMAGE_HEIGHT, pick_side());
      n = $urandom_range(8, 48);
      repeat (n) send_pixel(rand_pixel());
      random_sent += n;
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_blocks();
    test_tall_frame();
    test_random_traffic();
    if (expected_px.size() > 0) begin
      note_error();
      $display("%0d expected words never arrived", expected_px.size());
    end
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bap_pkg.sv
rtl/core/bap_ram.sv
rtl/core/bap_front.sv
rtl/core/bap_fifo.sv
rtl/core/bap_back.sv
rtl/core/block_average_pixelate_2x2.sv
test/tb_top.sv
